// ----- design/psg_pkg.sv -----
// Shared types, constants and the gain table of the PSG tone and noise generator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package psg_pkg;

  localparam int NumTones   = 3;
  localparam int PerW       = 10;   // periods are kept in units of 64
  localparam int CntW       = 18;   // signed period counters
  localparam int SampleW    = 15;

  localparam logic [2:0] RegNoiseCtl  = 3'd6;
  localparam logic [2:0] RegNoiseGain = 3'd7;

  localparam logic [PerW-1:0] PerReset = 10'h3FF;   // 0xFFC0 >> 6
  localparam logic [PerW-1:0] PerZero  = 10'd16;    // a zero period acts as 1024
  localparam logic [PerW-1:0] PerDcMax = 10'd4;     // 256 and below is DC
  localparam logic [PerW-1:0] NoiseBase = 10'd16;   // 0x400 >> 6

  localparam logic signed [CntW-1:0] ToneStep  = -18'sd8192;
  localparam logic signed [CntW-1:0] NoiseStep = -18'sd512;
  localparam logic [15:0] ShiftReset = 16'h4000;

  typedef struct packed {
    logic [NumTones-1:0][PerW-1:0] tone_per;
    logic [PerW-1:0]               noise_per;
    logic [3:0][3:0]               gain;        // index 3 is noise
    logic                          white;
  } psg_cfg_t;

  typedef struct packed {
    logic       clr_tone;
    logic [1:0] tone_idx;
    logic       clr_noise;
    logic       rst_shift;
  } psg_evt_t;

  function automatic logic [15:0] vol_lookup(input logic [3:0] idx);
    logic [15:0] v;
    case (idx)
      4'd0:  v = 16'd32767;
      4'd1:  v = 16'd26028;
      4'd2:  v = 16'd20675;
      4'd3:  v = 16'd16422;
      4'd4:  v = 16'd13045;
      4'd5:  v = 16'd10362;
      4'd6:  v = 16'd8231;
      4'd7:  v = 16'd6568;
      4'd8:  v = 16'd5193;
      4'd9:  v = 16'd4125;
      4'd10: v = 16'd3277;
      4'd11: v = 16'd2603;
      4'd12: v = 16'd2067;
      4'd13: v = 16'd1642;
      4'd14: v = 16'd1304;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  function automatic logic [PerW-1:0] eff_per(input logic [PerW-1:0] p);
    return (p == '0) ? PerZero : p;
  endfunction

endpackage
`default_nettype wire

// ----- design/psg_if.sv -----
// Valid/ready channel interfaces for the PSG: write/tick input items and sample items.
// Depends on psg_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface psg_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data;
  modport source (output valid, input ready, output kind, output data);
  modport sink   (input valid, output ready, input kind, input data);
endinterface

interface psg_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [psg_pkg::SampleW-1:0]   sample;
  modport source (output valid, input ready, output sample);
  modport sink   (input valid, output ready, input sample);
endinterface
`default_nettype wire

// ----- design/psg_regs.sv -----
// Register write decode: latch/data bytes into periods, gains and noise control.
// Depends on psg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module psg_regs (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire logic [7:0]        wr_data,
  output psg_pkg::psg_cfg_t      cfg,
  output psg_pkg::psg_evt_t      evt
);
  import psg_pkg::*;

  logic [NumTones-1:0][PerW-1:0] tper_r;
  logic [NumTones-1:0][3:0]      lo_r;
  logic [NumTones-1:0][5:0]      hi_r;
  logic [3:0][3:0]               gain_r;
  logic [PerW-1:0]               nper_r;
  logic [3:0]                    nctl_r;
  logic [2:0]                    latch_r;
  logic [1:0]                    last_r;

  logic       is_latch;
  logic [2:0] reg_sel;
  logic       noise_wr;

  assign is_latch = wr_data[7];
  assign reg_sel  = wr_data[6:4];
  assign noise_wr = wr_en && ((is_latch && reg_sel == RegNoiseCtl) ||
                              (!is_latch && latch_r == RegNoiseCtl));

  always_comb begin
    evt           = '0;
    evt.rst_shift = noise_wr;
    evt.clr_noise = noise_wr && (wr_data[1:0] != nctl_r[1:0]);
    evt.clr_tone  = wr_en && !is_latch && latch_r != RegNoiseCtl;
    evt.tone_idx  = last_r;
  end

  assign cfg.tone_per  = tper_r;
  assign cfg.noise_per = nper_r;
  assign cfg.gain      = gain_r;
  assign cfg.white     = nctl_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumTones; i++) begin
        tper_r[i] <= PerReset;
        lo_r[i]   <= '0;
        hi_r[i]   <= '0;
        gain_r[i] <= 4'd8;
      end
      gain_r[3] <= '0;
      nper_r    <= PerReset;
      nctl_r    <= 4'd3;
      latch_r   <= '0;
      last_r    <= '0;
    end else if (wr_en) begin
      if (noise_wr) begin
        nctl_r <= wr_data[3:0];
        if (wr_data[1:0] == 2'd3) nper_r <= tper_r[2];
        else                      nper_r <= NoiseBase << wr_data[1:0];
      end
      if (is_latch) begin
        latch_r <= reg_sel;
        if (reg_sel == RegNoiseGain) begin
          gain_r[3] <= ~wr_data[3:0];
        end else if (reg_sel != RegNoiseCtl) begin
          if (reg_sel[0]) begin
            gain_r[reg_sel[2:1]] <= ~wr_data[3:0];
          end else begin
            lo_r[reg_sel[2:1]]   <= wr_data[3:0];
            tper_r[reg_sel[2:1]] <= {hi_r[reg_sel[2:1]], wr_data[3:0]};
            last_r               <= reg_sel[2:1];
          end
        end
      end else if (latch_r != RegNoiseCtl) begin
        hi_r[last_r]   <= wr_data[5:0];
        tper_r[last_r] <= {wr_data[5:0], lo_r[last_r]};
        if (nctl_r[1:0] == 2'd3 && last_r == 2'd2) nper_r <= {wr_data[5:0], lo_r[last_r]};
      end
    end
  end
endmodule
`default_nettype wire

// ----- design/psg_engine.sv -----
// Sample sequencer: one shared multiply-add for mixing, one shared counter adder
// that steps the tone and noise counters one wrap per cycle. Depends on psg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module psg_engine (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic                        slot_free,
  input  psg_pkg::psg_cfg_t                cfg,
  input  psg_pkg::psg_evt_t                evt,
  output logic                             idle,
  output logic                             res_valid,
  output logic signed [psg_pkg::SampleW-1:0] res_sample
);
  import psg_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_MIX, S_SUB, S_LOOP, S_FIN} state_t;

  state_t                        state_r;
  logic [1:0]                    ch_r;
  logic signed [SampleW-1:0]     acc_r;
  logic signed [CntW-1:0]        cnt_r [4];
  logic [NumTones-1:0][4:0]      phase_r;
  logic [15:0]                   shift_r;

  logic [PerW-1:0]               ep;
  logic signed [8:0]             amp;
  logic [15:0]                   vol;
  logic signed [25:0]            prod;
  logic signed [SampleW-1:0]     term;
  logic signed [CntW-1:0]        addend;
  logic signed [CntW-1:0]        sum;
  logic                          fb;

  always_comb begin
    ep = (ch_r == 2'd3) ? eff_per(cfg.noise_per) : eff_per(cfg.tone_per[ch_r]);
    if (ch_r == 2'd3)
      amp = shift_r[0] ? 9'sd0 : 9'sd254;
    else if (ep <= PerDcMax || !phase_r[ch_r][4])
      amp = 9'sd127;
    else
      amp = -9'sd127;
    vol  = vol_lookup(~cfg.gain[ch_r]);
    prod = amp * $signed({1'b0, vol});
    term = prod[25:11];
    if (state_r == S_SUB)
      addend = (ch_r == 2'd3) ? NoiseStep : ToneStep;
    else if (ch_r == 2'd3)
      addend = $signed({1'b0, ep, 7'b0});
    else
      addend = $signed({2'b0, ep, 6'b0});
    sum = cnt_r[ch_r] + addend;
    fb  = cfg.white ? (shift_r[0] ^ shift_r[1]) : shift_r[0];
  end

  assign idle       = (state_r == S_IDLE);
  assign res_valid  = (state_r == S_FIN) && slot_free;
  assign res_sample = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ch_r    <= '0;
      acc_r   <= '0;
      for (int i = 0; i < 4; i++) cnt_r[i] <= '0;
      phase_r <= '0;
      shift_r <= ShiftReset;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (evt.clr_tone)  cnt_r[evt.tone_idx] <= '0;
          if (evt.clr_noise) cnt_r[3] <= '0;
          if (evt.rst_shift) shift_r <= ShiftReset;
          if (start) begin
            state_r <= S_MIX;
            ch_r    <= '0;
            acc_r   <= '0;
          end
        end
        S_MIX: begin
          acc_r <= acc_r + term;
          ch_r  <= ch_r + 2'd1;
          if (ch_r == 2'd3) state_r <= S_SUB;
        end
        S_SUB: begin
          cnt_r[ch_r] <= sum;
          state_r     <= S_LOOP;
        end
        S_LOOP: begin
          if (cnt_r[ch_r][CntW-1]) begin
            cnt_r[ch_r] <= sum;
            if (ch_r == 2'd3) shift_r <= {1'b0, shift_r[15] | fb, shift_r[14:1]};
            else              phase_r[ch_r] <= phase_r[ch_r] + 5'd1;
          end else if (ch_r == 2'd3) begin
            state_r <= S_FIN;
          end else begin
            ch_r    <= ch_r + 2'd1;
            state_r <= S_SUB;
          end
        end
        S_FIN: begin
          if (slot_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- design/psg_tone_noise_generator_unit.sv -----
// Top level of the PSG tone and noise generator: register decode, sample sequencer,
// output register. Depends on psg_pkg, psg_if, psg_regs, psg_engine.
//
//   channel  dir  payload            moves
//   in_ch    in   kind, data[7:0]    write byte (kind 0) or sample tick (kind 1)
//   out_ch   out  sample[14:0] s     one mixed sample per tick
//
// Write byte: decoded when accepted, no result.
// Tick: S_MIX adds in each of the four channels, then per channel S_SUB subtracts,
//   S_LOOP adds the period back once per counter wrap and then exits, and S_FIN hands
//   off. Wraps are 8192/period per tone (128 at the shortest period).
// The single counter adder steps one wrap per cycle, so the wraps set how long a tick lasts.
// in_ch.ready is high only while the sequencer is idle; a finished sample
// waits in the output register, and the sequencer holds if it is still full.
// Reset (rst_n low, synchronous) restores the power-up register values.
`timescale 1ns / 1ps
`default_nettype none
module psg_tone_noise_generator_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  psg_in_if.sink     in_ch,
  psg_out_if.source  out_ch
);
  import psg_pkg::*;

  psg_cfg_t                  cfg;
  psg_evt_t                  evt;
  logic                      eng_idle;
  logic                      res_valid;
  logic signed [SampleW-1:0] res_sample;
  logic                      in_acc;
  logic                      out_valid_r;
  logic signed [SampleW-1:0] sample_r;
  logic                      slot_free;

  assign in_ch.ready = eng_idle;
  assign in_acc      = in_ch.valid && eng_idle;
  assign slot_free   = !out_valid_r || out_ch.ready;

  psg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_acc && !in_ch.kind),
    .wr_data (in_ch.data),
    .cfg     (cfg),
    .evt     (evt)
  );

  psg_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_acc && in_ch.kind),
    .slot_free  (slot_free),
    .cfg        (cfg),
    .evt        (evt),
    .idle       (eng_idle),
    .res_valid  (res_valid),
    .res_sample (res_sample)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) sample_r <= res_sample;
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.sample = sample_r;
endmodule
`default_nettype wire

// ----- design/psg_checker.sv -----
// Port-level checks of the PSG top level, attached by bind.
// Depends on psg_pkg and psg_tone_noise_generator_unit.
`timescale 1ns / 1ps
`default_nettype none
module psg_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              in_kind,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic signed [psg_pkg::SampleW-1:0] out_sample
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("out valid dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_sample)) else $error("out sample moved");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind |=> !in_ready) else $error("ready after tick");

  a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_kind && !out_valid |=> !out_valid)
    else $error("result from write byte");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sample >= -15'sd6144) && (out_sample <= 15'sd10240))
    else $error("sample out of range");
endmodule

bind psg_tone_noise_generator_unit psg_checker u_psg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_kind    (in_ch.kind),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_sample (out_ch.sample)
);
`default_nettype wire
